@@ src/mde_pkg.sv @@
// shared types and field widths for the mean dispersion evaluator
`default_nettype none

package mde_pkg;

    localparam int ACTION_W     = 3;
    localparam int NODE_FIELD_W = 6;
    localparam int DIST_FIELD_W = 24;
    localparam int SUM_W        = 40;
    localparam int COUNT_W      = 7;
    localparam int ERR_W        = 3;

    // input tdata: node_a, node_b, distance, padded to whole bytes
    localparam int IN_A_LSB     = 0;
    localparam int IN_B_LSB     = IN_A_LSB + NODE_FIELD_W;
    localparam int IN_D_LSB     = IN_B_LSB + NODE_FIELD_W;
    localparam int IN_DATA_W    = ((IN_D_LSB + DIST_FIELD_W + 7) / 8) * 8;

    // output tdata: mean, edge_sum, member_count, padded to whole bytes
    localparam int OUT_MEAN_LSB = 0;
    localparam int OUT_SUM_LSB  = OUT_MEAN_LSB + SUM_W;
    localparam int OUT_CNT_LSB  = OUT_SUM_LSB + SUM_W;
    localparam int OUT_DATA_W   = ((OUT_CNT_LSB + COUNT_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 1 + ERR_W;

    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE      = 3'd0,
        ACT_EVAL_ADD   = 3'd1,
        ACT_EVAL_DEL   = 3'd2,
        ACT_COMMIT_ADD = 3'd3,
        ACT_COMMIT_DEL = 3'd4,
        ACT_MEAN       = 3'd5
    } action_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK         = 3'd0,
        ERR_RANGE      = 3'd1,
        ERR_DIAGONAL   = 3'd2,
        ERR_MEMBER     = 3'd3,
        ERR_NOT_MEMBER = 3'd4
    } err_t;

endpackage

`default_nettype wire

@@ src/mde_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module mde_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/mean_dispersion_evaluator.sv @@
// Mean dispersion move evaluator: a symmetric distance matrix in one ram,
// a solution bitmap, the edge sum of the solution and its member count. Each
// input transfer carries one action (write a distance, evaluate an add or a
// delete, commit an add or a delete, report the current mean) and gives one
// output transfer with the resulting mean, edge sum, member count and error
// code. After reset the matrix ram is swept to zero, one entry a cycle, over
// all 2**(2*clog2(MAX_NODES)) entries (4096 at the default size); no input is
// taken during that sweep, while configuration writes are. An item that reports
// a mean or is rejected with an error goes from decode straight to the divider,
// a distance write first writes both entries of the symmetric pair, and an
// evaluated or committed move first runs the member walk: it reads one matrix
// row entry per cycle for all MAX_NODES rows. The mean then goes through a
// 40-step restoring divider, which is skipped when the mean is undefined. A
// result that is not taken holds the next item in the output state. One item
// is worked on at a time; the next one is taken while the previous result
// still waits in the output register.
`default_nettype none

module mean_dispersion_evaluator
    import mde_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int DIST_BITS = 24
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration: node_count
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [COUNT_W-1:0]    cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // node_a [5:0], node_b [11:6], distance [35:12], zero fill
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // action [2:0]
    input  wire logic [ACTION_W-1:0]   s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // mean [39:0], edge_sum [79:40], member_count [86:80], zero fill
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // mean_valid [0], error [3:1]
    output logic [OUT_USER_W-1:0]      m_tuser
);

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int ADDR_W = 2 * NODE_W;
    localparam int DEPTH  = 1 << ADDR_W;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_WR_OLD,
        ST_WR_SYM,
        ST_WALK,
        ST_DRAIN,
        ST_APPLY,
        ST_DIV_START,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                   state_reg;
    logic [ADDR_W-1:0]        clr_addr_reg;
    logic [COUNT_W-1:0]       node_count_reg;
    logic [MAX_NODES-1:0]     member_reg;
    logic [SUM_W-1:0]         cur_sum_reg;
    logic [CNT_W-1:0]         size_reg;

    logic [ACTION_W-1:0]      act_reg;
    logic [NODE_FIELD_W-1:0]  a_reg;
    logic [NODE_FIELD_W-1:0]  b_reg;
    logic [DIST_BITS-1:0]     d_reg;

    logic [NODE_W-1:0]        k_reg;
    logic                     pend_reg;
    logic [SUM_W-1:0]         acc_reg;

    logic [SUM_W-1:0]         res_sum_reg;
    logic [CNT_W-1:0]         div_reg;
    logic                     allow_reg;
    err_t                     err_reg;
    logic                     neg_reg;
    logic [SUM_W-1:0]         q_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [STEP_W-1:0]        step_reg;

    logic                     m_tvalid_reg;
    logic [SUM_W-1:0]         mean_out_reg;
    logic                     valid_out_reg;
    logic [SUM_W-1:0]         sum_out_reg;
    logic [COUNT_W-1:0]       count_out_reg;
    err_t                     err_out_reg;

    // input field unpacking
    logic [NODE_FIELD_W-1:0]      in_a;
    logic [NODE_FIELD_W-1:0]      in_b;
    logic [DIST_FIELD_W-1:0]      in_dist;
    logic [DIST_BITS+DIST_FIELD_W-1:0] in_dist_wide;

    assign in_a         = s_tdata[IN_A_LSB +: NODE_FIELD_W];
    assign in_b         = s_tdata[IN_B_LSB +: NODE_FIELD_W];
    assign in_dist      = s_tdata[IN_D_LSB +: DIST_FIELD_W];
    assign in_dist_wide = {{DIST_BITS{1'b0}}, in_dist};

    // node indexes and range checks
    logic [CMP_W-1:0]  a_ext;
    logic [CMP_W-1:0]  b_ext;
    logic [NODE_W-1:0] a_idx;
    logic [NODE_W-1:0] b_idx;
    logic              a_ok;
    logic              b_ok;
    logic              a_member;

    assign a_ext    = CMP_W'(a_reg);
    assign b_ext    = CMP_W'(b_reg);
    assign a_idx    = a_ext[NODE_W-1:0];
    assign b_idx    = b_ext[NODE_W-1:0];
    assign a_ok     = (a_ext < CMP_W'(node_count_reg)) && (a_ext < CMP_W'(MAX_NODES));
    assign b_ok     = (b_ext < CMP_W'(node_count_reg)) && (b_ext < CMP_W'(MAX_NODES));
    assign a_member = member_reg[a_idx];

    // decode outcome: error code and the state that follows decode
    err_t   dec_err;
    state_t dec_state;

    always_comb
    begin
        dec_err   = ERR_OK;
        dec_state = ST_DIV_START;
        if (act_reg <= ACT_COMMIT_DEL)
        begin
            if (!a_ok || (act_reg == ACT_WRITE && !b_ok))
            begin
                dec_err = ERR_RANGE;
            end
            else if (act_reg == ACT_WRITE)
            begin
                if (a_idx == b_idx)
                begin
                    dec_err = ERR_DIAGONAL;
                end
                else
                begin
                    dec_state = ST_WR_OLD;
                end
            end
            else if ((act_reg == ACT_EVAL_ADD || act_reg == ACT_COMMIT_ADD) && a_member)
            begin
                dec_err = ERR_MEMBER;
            end
            else if ((act_reg == ACT_EVAL_DEL || act_reg == ACT_COMMIT_DEL) && !a_member)
            begin
                dec_err = ERR_NOT_MEMBER;
            end
            else
            begin
                dec_state = ST_WALK;
            end
        end
    end

    // matrix ram
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [DIST_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [DIST_BITS-1:0] ram_rdata;
    logic [SUM_W-1:0]     rd_ext;
    logic [SUM_W-1:0]     d_ext;

    assign rd_ext = {{(SUM_W-DIST_BITS){ram_rdata[DIST_BITS-1]}}, ram_rdata};
    assign d_ext  = {{(SUM_W-DIST_BITS){d_reg[DIST_BITS-1]}}, d_reg};

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {a_idx, b_idx};
        ram_wdata = d_reg;
        ram_raddr = {a_idx, b_idx};
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_WR_OLD:
            begin
                ram_we    = 1'b1;
                ram_waddr = {a_idx, b_idx};
            end
            ST_WR_SYM:
            begin
                ram_we    = 1'b1;
                ram_waddr = {b_idx, a_idx};
            end
            ST_WALK:
            begin
                ram_raddr = {k_reg, a_idx};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    mde_ram #(
        .WIDTH (DIST_BITS),
        .DEPTH (DEPTH)
    ) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // divider step
    logic [CNT_W:0]      div_trial;
    logic                div_fit;
    logic [SUM_W-1:0]    res_mag;
    logic                div_ok;
    logic [COUNT_W-1:0]  size_port;

    assign div_trial = {rem_reg, q_reg[SUM_W-1]};
    assign div_fit   = div_trial >= {1'b0, div_reg};
    assign res_mag   = res_sum_reg[SUM_W-1] ? (~res_sum_reg + 1'b1) : res_sum_reg;
    assign div_ok    = allow_reg && (div_reg != '0);
    assign size_port = COUNT_W'(CMP_W'(size_reg));

    logic out_free;
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            node_count_reg <= NODE_COUNT_RESET;
            member_reg     <= '0;
            cur_sum_reg    <= '0;
            size_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                node_count_reg <= cfg_data;
            end
            // the output state reloads the register itself
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT)
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == {ADDR_W{1'b1}})
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        act_reg   <= s_tuser;
                        a_reg     <= in_a;
                        b_reg     <= in_b;
                        d_reg     <= in_dist_wide[DIST_BITS-1:0];
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE:
                begin
                    // default: report the current mean
                    res_sum_reg <= cur_sum_reg;
                    div_reg     <= size_reg;
                    allow_reg   <= 1'b1;
                    err_reg     <= dec_err;
                    k_reg       <= '0;
                    pend_reg    <= 1'b0;
                    acc_reg     <= '0;
                    state_reg   <= dec_state;
                end
                ST_WR_OLD:
                begin
                    // old value read in decode, adjust the sum for a member edge
                    if (a_member && member_reg[b_idx])
                    begin
                        cur_sum_reg <= cur_sum_reg + d_ext - rd_ext;
                    end
                    state_reg <= ST_WR_SYM;
                end
                ST_WR_SYM:
                begin
                    res_sum_reg <= cur_sum_reg;
                    state_reg   <= ST_DIV_START;
                end
                ST_WALK:
                begin
                    pend_reg <= member_reg[k_reg];
                    if (pend_reg)
                    begin
                        acc_reg <= acc_reg + rd_ext;
                    end
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == NODE_W'(MAX_NODES - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (pend_reg)
                    begin
                        acc_reg <= acc_reg + rd_ext;
                    end
                    state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    state_reg <= ST_DIV_START;
                    case (act_reg)
                        ACT_EVAL_ADD:
                        begin
                            res_sum_reg <= cur_sum_reg + acc_reg;
                            div_reg     <= size_reg + 1'b1;
                            allow_reg   <= (size_reg != '0);
                        end
                        ACT_EVAL_DEL:
                        begin
                            res_sum_reg <= cur_sum_reg - acc_reg;
                            div_reg     <= size_reg - 1'b1;
                        end
                        ACT_COMMIT_ADD:
                        begin
                            cur_sum_reg       <= cur_sum_reg + acc_reg;
                            res_sum_reg       <= cur_sum_reg + acc_reg;
                            member_reg[a_idx] <= 1'b1;
                            size_reg          <= size_reg + 1'b1;
                            div_reg           <= size_reg + 1'b1;
                        end
                        default:
                        begin
                            cur_sum_reg       <= cur_sum_reg - acc_reg;
                            res_sum_reg       <= cur_sum_reg - acc_reg;
                            member_reg[a_idx] <= 1'b0;
                            size_reg          <= size_reg - 1'b1;
                            div_reg           <= size_reg - 1'b1;
                        end
                    endcase
                end
                ST_DIV_START:
                begin
                    rem_reg  <= '0;
                    step_reg <= '0;
                    if (div_ok)
                    begin
                        neg_reg   <= res_sum_reg[SUM_W-1];
                        q_reg     <= res_mag;
                        state_reg <= ST_DIV;
                    end
                    else
                    begin
                        q_reg     <= '0;
                        neg_reg   <= 1'b0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_DIV:
                begin
                    // restoring step, quotient bits shift in behind the dividend
                    if (div_fit)
                    begin
                        rem_reg <= CNT_W'(div_trial - {1'b0, div_reg});
                    end
                    else
                    begin
                        rem_reg <= div_trial[CNT_W-1:0];
                    end
                    q_reg    <= {q_reg[SUM_W-2:0], div_fit};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(SUM_W - 1))
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg  <= 1'b1;
                        mean_out_reg  <= neg_reg ? (~q_reg + 1'b1) : q_reg;
                        valid_out_reg <= div_ok;
                        sum_out_reg   <= res_sum_reg;
                        count_out_reg <= size_port;
                        err_out_reg   <= err_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(OUT_DATA_W-OUT_CNT_LSB-COUNT_W){1'b0}},
                        count_out_reg, sum_out_reg, mean_out_reg};
    assign m_tuser   = {err_out_reg, valid_out_reg};

`ifndef SYNTHESIS
    a_count_matches_bitmap: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(member_reg) == int'(size_reg))
        else $error("member count differs from solution bitmap");

    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result issued outside the output state");

    a_remainder_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire
